// ===== rtl/core/voxel_occupancy_grid_defines.svh =====
// ---------------------------------------------------------------------------
// voxel_occupancy_grid_defines
// assertion macros used by voxel_occupancy_grid
// ---------------------------------------------------------------------------
`ifndef VOXEL_OCCUPANCY_GRID_DEFINES_SVH
`define VOXEL_OCCUPANCY_GRID_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define VOG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voxel grid check failed");

// next-cycle implication
`define VOG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voxel grid check failed");

`endif

// ===== rtl/core/vog_pkg.sv =====
// ---------------------------------------------------------------------------
// vog_pkg
// shared constants, codes and types of the voxel occupancy grid
// ---------------------------------------------------------------------------
package vog_pkg;

  localparam int DEF_MAX_CELLS = 64;

  localparam int COORD_W    = 32;
  localparam int RES_W      = 31;
  localparam int CELLS_W    = 7;
  localparam int IDX_W      = 9;   // holds any cell count up to 256
  localparam int CNT_W      = 19;
  localparam int CODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [RES_W-1:0]   RES_RESET   = RES_W'(65536);
  localparam logic [CELLS_W-1:0] CELLS_RESET = CELLS_W'(64);

  // voxel codes
  localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_FREE     = 2'd1;
  localparam logic [CODE_W-1:0] CODE_OCCUPIED = 2'd2;

  // operations
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RESOLUTION = 3'd3,
    REG_CELLS_X    = 3'd4,
    REG_CELLS_Y    = 3'd5,
    REG_CELLS_Z    = 3'd6
  } cfg_reg_t;

  // per-axis result handed to the control
  typedef struct packed {
    logic             done;
    logic             in_span;
    logic [IDX_W-1:0] idx;
  } axis_res_t;

endpackage

// ===== rtl/core/vog_ram.sv =====
// ---------------------------------------------------------------------------
// vog_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module vog_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 262144,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/vog_axis.sv =====
// ---------------------------------------------------------------------------
// vog_axis
// one axis: span, bounds check and bit-serial floor divide for the index
// ---------------------------------------------------------------------------
module vog_axis #(
  parameter int MAX_CELLS = vog_pkg::DEF_MAX_CELLS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [vog_pkg::COORD_W-1:0] point,
  input  logic signed [vog_pkg::COORD_W-1:0] center,
  input  logic [vog_pkg::RES_W-1:0]          res,
  input  logic [vog_pkg::IDX_W-1:0]          cells,
  output vog_pkg::axis_res_t                 result
);
  import vog_pkg::*;

  localparam int NW = $clog2(MAX_CELLS + 1);
  localparam int QW = NW;
  localparam int SW = RES_W + NW;
  localparam int OW = ((SW > 33) ? SW : 33) + 2;
  localparam int DW = OW + QW;
  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  typedef enum logic [2:0] {
    A_IDLE, A_SPAN, A_OFF, A_CHK, A_DIV, A_DONE
  } axis_state_t;

  axis_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] p_r, c_r;
  logic [RES_W-1:0]          res_r;
  logic [NW-1:0]             n_r;
  logic [SW-1:0]             span_r;
  logic signed [OW-1:0]      off2_r;
  logic                      inside_r;
  logic [DW-1:0]             rem_r, dsh_r;
  logic [QW-1:0]             q_r;
  logic [CW-1:0]             cnt_r;

  logic signed [OW-1:0] diff, span_s;
  logic [NW-1:0]        last_idx;
  logic                 take;

  assign diff     = OW'(p_r) - OW'(c_r);
  assign span_s   = OW'(signed'({1'b0, span_r}));
  assign last_idx = n_r - NW'(1);
  assign take     = rem_r >= dsh_r;

  // sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE:  if (start) state_nxt = A_SPAN;
      A_SPAN:  state_nxt = A_OFF;
      A_OFF:   state_nxt = A_CHK;
      A_CHK:   state_nxt = A_DIV;
      A_DIV:   if (cnt_r == CW'(QW - 1)) state_nxt = A_DONE;
      A_DONE:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        if (start) begin
          p_r   <= point;
          c_r   <= center;
          res_r <= res;
          n_r   <= NW'(cells);
        end
      end
      A_SPAN: begin
        span_r <= SW'(res_r * n_r);
      end
      A_OFF: begin
        off2_r <= (diff <<< 1) + span_s;
      end
      A_CHK: begin
        inside_r <= !off2_r[OW-1] && ($unsigned(off2_r) <= OW'({span_r, 1'b0}));
        rem_r    <= DW'($unsigned(off2_r));
        dsh_r    <= DW'({res_r, 1'b0}) << (QW - 1);
        q_r      <= '0;
        cnt_r    <= '0;
      end
      A_DIV: begin
        // one quotient bit a cycle, msb first
        if (take) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r   <= (q_r << 1) | QW'(take);
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // result held once the divide is through; clamp a point on the upper face
  always_comb begin
    result.done    = (state_r == A_DONE) || (state_r == A_IDLE);
    result.in_span = inside_r;
    result.idx     = (q_r > last_idx) ? IDX_W'(last_idx) : IDX_W'(q_r);
  end

endmodule

// ===== rtl/core/voxel_occupancy_grid.sv =====
// ---------------------------------------------------------------------------
// voxel_occupancy_grid
// dense 3d occupancy grid: insert and query of q16.16 world points
// ---------------------------------------------------------------------------
//   channel  direction  handshake         payload
//   in       input      in_valid/ready    operation, point_x/y/z, mark_occupied
//   out      output     out_valid/ready   status, cell_value, occupied_count,
//                                         total_cells
//   cfg      input      cfg_valid/ready   cfg_index, cfg_data
//
// one item at a time; a point inside the grid passes through the bit-serial
// quotient of the three axis dividers and then the voxel read-modify-write;
// a point outside skips the store. after reset a clearing pass writes every
// voxel unknown, one per cycle; in_ready stays low during it.
// a waiting result does not block the next transfer; the following result
// holds until the output register is free.
`include "voxel_occupancy_grid_defines.svh"

module voxel_occupancy_grid #(
  parameter int MAX_CELLS_X = vog_pkg::DEF_MAX_CELLS,
  parameter int MAX_CELLS_Y = vog_pkg::DEF_MAX_CELLS,
  parameter int MAX_CELLS_Z = vog_pkg::DEF_MAX_CELLS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic signed [vog_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [vog_pkg::COORD_W-1:0]   in_point_y,
  input  logic signed [vog_pkg::COORD_W-1:0]   in_point_z,
  input  logic                                 in_mark_occupied,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_status,
  output logic [vog_pkg::CODE_W-1:0]           out_cell_value,
  output logic [vog_pkg::CNT_W-1:0]            out_occupied_count,
  output logic [vog_pkg::CNT_W-1:0]            out_total_cells,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vog_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vog_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import vog_pkg::*;

  localparam int DEPTH = MAX_CELLS_X * MAX_CELLS_Y * MAX_CELLS_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GEO, S_WAIT, S_ADDR1, S_ADDR2, S_READ, S_MOD, S_DONE
  } grid_state_t;

  grid_state_t state_r, state_nxt;

  // configuration registers
  logic signed [COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [RES_W-1:0]          resolution_r;
  logic [CELLS_W-1:0]        cells_x_r, cells_y_r, cells_z_r;

  // item and datapath registers
  logic                 op_r, mark_r, inside_r;
  logic [IDX_W-1:0]     i_r, j_r, k_r;
  logic [2*IDX_W-1:0]   nxy_r;
  logic [3*IDX_W-1:0]   tot_r;
  logic [AW-1:0]        addr_a_r, addr_r, clr_cnt_r;
  logic [CNT_W-1:0]     tally_r;
  logic                 res_status_r;
  logic [CODE_W-1:0]    res_value_r;

  logic                 out_valid_r, out_status_r;
  logic [CODE_W-1:0]    out_value_r;
  logic [CNT_W-1:0]     out_count_r, out_total_r;

  logic                 in_xfer, cfg_xfer, out_load, axes_done;
  logic [RES_W-1:0]     res_eff;
  logic [IDX_W-1:0]     nx_eff, ny_eff, nz_eff;
  axis_res_t            ax_x, ax_y, ax_z;
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr;
  logic [CODE_W-1:0]    wr_data, rd_data, new_code;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign axes_done = ax_x.done && ax_y.done && ax_z.done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      center_z_r   <= '0;
      resolution_r <= RES_RESET;
      cells_x_r    <= CELLS_RESET;
      cells_y_r    <= CELLS_RESET;
      cells_z_r    <= CELLS_RESET;
    end else if (cfg_xfer) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:   center_x_r   <= signed'(cfg_data);
        REG_CENTER_Y:   center_y_r   <= signed'(cfg_data);
        REG_CENTER_Z:   center_z_r   <= signed'(cfg_data);
        REG_RESOLUTION: resolution_r <= cfg_data[RES_W-1:0];
        REG_CELLS_X:    cells_x_r    <= cfg_data[CELLS_W-1:0];
        REG_CELLS_Y:    cells_y_r    <= cfg_data[CELLS_W-1:0];
        REG_CELLS_Z:    cells_z_r    <= cfg_data[CELLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective geometry: zero counts and resolution used as one, counts capped
  always_comb begin
    res_eff = (resolution_r == '0) ? RES_W'(1) : resolution_r;
    nx_eff  = (cells_x_r == '0) ? IDX_W'(1) :
              (IDX_W'(cells_x_r) > IDX_W'(MAX_CELLS_X)) ? IDX_W'(MAX_CELLS_X) :
              IDX_W'(cells_x_r);
    ny_eff  = (cells_y_r == '0) ? IDX_W'(1) :
              (IDX_W'(cells_y_r) > IDX_W'(MAX_CELLS_Y)) ? IDX_W'(MAX_CELLS_Y) :
              IDX_W'(cells_y_r);
    nz_eff  = (cells_z_r == '0) ? IDX_W'(1) :
              (IDX_W'(cells_z_r) > IDX_W'(MAX_CELLS_Z)) ? IDX_W'(MAX_CELLS_Z) :
              IDX_W'(cells_z_r);
  end

  // axis units start together; each holds its result until the next start
  vog_axis #(.MAX_CELLS(MAX_CELLS_X)) u_axis_x (
    .clk(clk), .rst_n(rst_n), .start(in_xfer), .point(in_point_x),
    .center(center_x_r), .res(res_eff), .cells(nx_eff), .result(ax_x)
  );
  vog_axis #(.MAX_CELLS(MAX_CELLS_Y)) u_axis_y (
    .clk(clk), .rst_n(rst_n), .start(in_xfer), .point(in_point_y),
    .center(center_y_r), .res(res_eff), .cells(ny_eff), .result(ax_y)
  );
  vog_axis #(.MAX_CELLS(MAX_CELLS_Z)) u_axis_z (
    .clk(clk), .rst_n(rst_n), .start(in_xfer), .point(in_point_z),
    .center(center_z_r), .res(res_eff), .cells(nz_eff), .result(ax_z)
  );

  // voxel store port use: clearing pass or insert write-back, read in S_READ
  assign new_code = mark_r ? CODE_OCCUPIED : CODE_FREE;
  assign wr_en    = (state_r == S_CLEAR) || ((state_r == S_MOD) && (op_r == OP_INSERT));
  assign wr_addr  = (state_r == S_CLEAR) ? clr_cnt_r : addr_r;
  assign wr_data  = (state_r == S_CLEAR) ? CODE_UNKNOWN : new_code;
  assign rd_en    = (state_r == S_READ);

  vog_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(addr_r), .rd_data(rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_xfer) state_nxt = S_GEO;
      S_GEO:   state_nxt = S_WAIT;
      S_WAIT:  if (axes_done) state_nxt = S_ADDR1;
      S_ADDR1: state_nxt = inside_r ? S_ADDR2 : S_DONE;
      S_ADDR2: state_nxt = S_READ;
      S_READ:  state_nxt = S_MOD;
      S_MOD:   state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, tally and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      // tally follows changes into and out of occupied
      if ((state_r == S_MOD) && (op_r == OP_INSERT)) begin
        if ((rd_data == CODE_OCCUPIED) && (new_code != CODE_OCCUPIED)) begin
          tally_r <= tally_r - CNT_W'(1);
        end else if ((rd_data != CODE_OCCUPIED) && (new_code == CODE_OCCUPIED)) begin
          tally_r <= tally_r + CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_operation;
      mark_r <= in_mark_occupied;
    end
    if (state_r == S_GEO) begin
      nxy_r <= nx_eff * ny_eff;
    end
    if (state_r == S_WAIT) begin
      tot_r <= (3*IDX_W)'(nxy_r * nz_eff);
      if (axes_done) begin
        inside_r <= ax_x.in_span && ax_y.in_span && ax_z.in_span;
        i_r      <= ax_x.idx;
        j_r      <= ax_y.idx;
        k_r      <= ax_z.idx;
      end
    end
    if (state_r == S_ADDR1) begin
      addr_a_r     <= AW'(i_r + j_r * nx_eff);
      res_status_r <= !inside_r;
      res_value_r  <= CODE_UNKNOWN;
    end
    if (state_r == S_ADDR2) begin
      addr_r <= AW'(addr_a_r + k_r * nxy_r);
    end
    if (state_r == S_MOD) begin
      res_value_r <= (op_r == OP_QUERY) ? rd_data : CODE_UNKNOWN;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_count_r  <= tally_r;
      out_total_r  <= CNT_W'(tot_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_cell_value     = out_value_r;
  assign out_occupied_count = out_count_r;
  assign out_total_cells    = out_total_r;

  // checks
  `VOG_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  `VOG_ASSERT_IMPL(a_outside_no_value, out_valid && out_status, out_cell_value == CODE_UNKNOWN)
  `VOG_ASSERT_IMPL(a_tally_only_on_write, tally_r != $past(tally_r), $past(state_r) == S_MOD)

endmodule

// ===== tb/sv/tb_voxel_occupancy_grid.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_voxel_occupancy_grid
// self-checking bench for the dense voxel occupancy grid
// ---------------------------------------------------------------------------
// a short directed table runs on the reset geometry first. several grid
// settings follow, including zero, overflowing and extreme register values.
// each setting gets random insert and query transfers under different
// sender and receiver idling. every result is checked field by field
// against a typed table entry or an in-bench occupancy model.
module tb_voxel_occupancy_grid;
  import vog_pkg::*;

  localparam int  STORE_CELLS = 64 * 64 * 64;
  localparam int  IDLE_LIMIT  = 1200000;  // several times the clearing pass after reset
  localparam int  DRAIN_WAIT  = 40;

  typedef struct packed {
    logic             status;
    logic [CODE_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] total;
  } grid_result_t;

  typedef struct {
    logic        op;
    logic [31:0] x, y, z;
    logic        occ;
    bit          typed;
    grid_result_t res;
  } grid_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic in_operation = 1'b0, in_mark_occupied = 1'b0;
  logic signed [COORD_W-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic out_status;
  logic [CODE_W-1:0] out_cell_value;
  logic [CNT_W-1:0] out_occupied_count, out_total_cells;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  voxel_occupancy_grid dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // grid model state
  logic [CODE_W-1:0] voxel_mem [0:STORE_CELLS-1];
  int unsigned occ_tally;
  longint ctr_x, ctr_y, ctr_z;
  logic [RES_W-1:0] res_reg;
  logic [CELLS_W-1:0] nx_reg, ny_reg, nz_reg;

  grid_result_t pending_results[$];
  int errors, items_sent, results_seen, outside_seen;
  int tx_idle_pct, rx_stall_pct;

  // map one coordinate to a slot along an axis, 0 when outside
  function automatic bit axis_slot(longint p, longint c, longint r, longint n,
                                   output longint idx);
    longint span, off2, q;
    span = r * n;
    off2 = 2 * (p - c) + span;
    idx = 0;
    if (off2 < 0 || off2 > 2 * span) return 1'b0;
    q = off2 / (2 * r);
    if (q > n - 1) q = n - 1;
    idx = q;
    return 1'b1;
  endfunction

  function automatic longint clamp_cells(logic [CELLS_W-1:0] n);
    if (n == 0) return 1;
    if (n > 64) return 64;
    return longint'(n);
  endfunction

  // apply one point to the model grid and give the result it must produce
  function automatic grid_result_t grid_apply(logic op, logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z, logic occ);
    grid_result_t r;
    longint nx, ny, nz, rs, i, j, k;
    int unsigned addr;
    logic [CODE_W-1:0] old, nw;
    nx = clamp_cells(nx_reg);
    ny = clamp_cells(ny_reg);
    nz = clamp_cells(nz_reg);
    rs = (res_reg == 0) ? 1 : longint'(res_reg);
    r.status = 1'b1;
    r.value = CODE_UNKNOWN;
    if (axis_slot(longint'($signed(x)), ctr_x, rs, nx, i) &&
        axis_slot(longint'($signed(y)), ctr_y, rs, ny, j) &&
        axis_slot(longint'($signed(z)), ctr_z, rs, nz, k)) begin
      addr = int'(i + j * nx + k * nx * ny);
      old = voxel_mem[addr];
      r.status = 1'b0;
      if (op == OP_QUERY) begin
        r.value = old;
      end else begin
        nw = occ ? CODE_OCCUPIED : CODE_FREE;
        if (old == CODE_OCCUPIED && nw != CODE_OCCUPIED) occ_tally--;
        if (old != CODE_OCCUPIED && nw == CODE_OCCUPIED) occ_tally++;
        voxel_mem[addr] = nw;
      end
    end
    r.count = CNT_W'(occ_tally);
    r.total = CNT_W'(nx * ny * nz);
    return r;
  endfunction

  // offer one point and wait for its transfer
  task automatic send_point(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic occ, bit typed, grid_result_t typed_res);
    grid_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    in_mark_occupied <= occ;
    do @(posedge clk); while (!in_ready);
    r = grid_apply(op, x, y, z, occ);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTER_X:   ctr_x = longint'($signed(data));
      REG_CENTER_Y:   ctr_y = longint'($signed(data));
      REG_CENTER_Z:   ctr_z = longint'($signed(data));
      REG_RESOLUTION: res_reg = data[RES_W-1:0];
      REG_CELLS_X:    nx_reg = data[CELLS_W-1:0];
      REG_CELLS_Y:    ny_reg = data[CELLS_W-1:0];
      REG_CELLS_Z:    nz_reg = data[CELLS_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                          logic [31:0] rs, logic [31:0] nx, logic [31:0] ny,
                          logic [31:0] nz);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RESOLUTION, rs);
    write_reg(REG_CELLS_X, nx);
    write_reg(REG_CELLS_Y, ny);
    write_reg(REG_CELLS_Z, nz);
  endtask

  // coordinate near or inside the current span of one axis
  function automatic logic [31:0] pick_coord(longint c, logic [CELLS_W-1:0] ncode);
    longint rs, n, lo, p;
    int sel;
    rs = (res_reg == 0) ? 1 : longint'(res_reg);
    n = clamp_cells(ncode);
    lo = c - (rs * n) / 2;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom;
    if (sel == 1) begin
      p = ($urandom_range(1) ? lo : c + (rs * n + 1) / 2) + $urandom_range(2) - 1;
    end else begin
      p = lo + longint'($urandom_range(int'(n) - 1)) * rs + longint'($urandom) % rs;
    end
    return p[31:0];
  endfunction

  task automatic random_points(int count, bit pause_midway);
    logic [31:0] x, y, z;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) begin
        release_input();
        while (pending_results.size() != 0) @(posedge clk);
      end
      x = pick_coord(ctr_x, nx_reg);
      y = pick_coord(ctr_y, ny_reg);
      z = pick_coord(ctr_z, nz_reg);
      send_point($urandom_range(1), x, y, z, $urandom_range(1), 1'b0, '0);
    end
    release_input();
  endtask

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_stall_pct);

  // result checking
  always @(posedge clk) begin
    grid_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (e.status) outside_seen++;
        if (e.status != out_status || e.value != out_cell_value ||
            e.count != out_occupied_count || e.total != out_total_cells) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at %0t: status %0d/%0d value %0d/%0d count %0d/%0d total %0d/%0d",
                     $realtime, e.status, out_status, e.value, out_cell_value,
                     e.count, out_occupied_count, e.total, out_total_cells);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("voxel_occupancy_grid verification failed");
      $finish;
    end
  end

  // directed rows on the reset geometry: span -32.0 .. 32.0 on each axis
  grid_row_t directed [] = '{
    '{OP_QUERY,  32'h0, 32'h0, 32'h0, 1'b0, 1, '{1'b0, CODE_UNKNOWN, 19'd0, 19'd262144}},
    '{OP_INSERT, 32'h0, 32'h0, 32'h0, 1'b1, 1, '{1'b0, CODE_UNKNOWN, 19'd1, 19'd262144}},
    '{OP_QUERY,  32'h0, 32'h0, 32'h0, 1'b0, 1, '{1'b0, CODE_OCCUPIED, 19'd1, 19'd262144}},
    '{OP_INSERT, 32'h0, 32'h0, 32'h0, 1'b0, 1, '{1'b0, CODE_UNKNOWN, 19'd0, 19'd262144}},
    '{OP_QUERY,  32'h0, 32'h0, 32'h0, 1'b1, 1, '{1'b0, CODE_FREE, 19'd0, 19'd262144}},
    // upper face clamps to the last voxel
    '{OP_QUERY,  32'h200000, 32'h200000, 32'h200000, 1'b0, 1,
      '{1'b0, CODE_UNKNOWN, 19'd0, 19'd262144}},
    '{OP_INSERT, 32'h200000, 32'h200000, 32'h200000, 1'b1, 1,
      '{1'b0, CODE_UNKNOWN, 19'd1, 19'd262144}},
    '{OP_QUERY,  32'h1FFFFF, 32'h1F8000, 32'h1F0001, 1'b0, 0, '0},
    // rewriting an occupied voxel leaves the tally alone
    '{OP_INSERT, 32'h200000, 32'h200000, 32'h200000, 1'b1, 1,
      '{1'b0, CODE_UNKNOWN, 19'd1, 19'd262144}},
    '{OP_QUERY,  32'hFFE00000, 32'hFFE00000, 32'hFFE00000, 1'b0, 1,
      '{1'b0, CODE_UNKNOWN, 19'd1, 19'd262144}},
    '{OP_INSERT, 32'hFFE00000, 32'h200000, 32'h0, 1'b1, 0, '0},
    // just outside, and the coordinate extremes
    '{OP_QUERY,  32'h200001, 32'h0, 32'h0, 1'b0, 1, '{1'b1, CODE_UNKNOWN, 19'd2, 19'd262144}},
    '{OP_INSERT, 32'h0, 32'hFFDFFFFF, 32'h0, 1'b1, 1, '{1'b1, CODE_UNKNOWN, 19'd2, 19'd262144}},
    '{OP_QUERY,  32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1,
      '{1'b1, CODE_UNKNOWN, 19'd2, 19'd262144}},
    '{OP_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1,
      '{1'b1, CODE_UNKNOWN, 19'd2, 19'd262144}},
    '{OP_INSERT, 32'hFFE00000, 32'h200000, 32'h0, 1'b0, 0, '0},
    '{OP_QUERY,  32'hFFE00000, 32'h200000, 32'h0, 1'b0, 0, '0}
  };

  initial begin
    for (int a = 0; a < STORE_CELLS; a++) voxel_mem[a] = CODE_UNKNOWN;
    occ_tally = 0;
    ctr_x = 0; ctr_y = 0; ctr_z = 0;
    res_reg = RES_RESET;
    nx_reg = CELLS_RESET; ny_reg = CELLS_RESET; nz_reg = CELLS_RESET;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[r])
      send_point(directed[r].op, directed[r].x, directed[r].y, directed[r].z,
                 directed[r].occ, directed[r].typed, directed[r].res);
    release_input();
    random_points(60, 1'b0);
    wait_drained();

    // small grid, fine resolution, offset center
    set_grid(32'h00030000, 32'hFFFD0000, 32'h00008000, 32'h00004000, 4, 4, 4);
    tx_idle_pct = 72;
    random_points(150, 1'b1);
    wait_drained();

    // zero counts and zero resolution fall back to one
    set_grid(32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0);
    tx_idle_pct = 0; rx_stall_pct = 72;
    random_points(100, 1'b0);
    wait_drained();

    // counts above the maximum with the largest resolution
    set_grid(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF, 127, 127, 127);
    tx_idle_pct = 20; rx_stall_pct = 20;
    random_points(140, 1'b0);
    wait_drained();

    // thin slabs at the center extremes, upper bits of the data ignored
    set_grid(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000001, 32'hFFFFFF81, 2, 64);
    tx_idle_pct = 0; rx_stall_pct = 0;
    random_points(150, 1'b0);
    wait_drained();

    // resized grid over the stored codes
    set_grid(32'h0, 32'h0, 32'h0, 32'h00010000, 3, 5, 7);
    tx_idle_pct = 72; rx_stall_pct = 72;
    random_points(180, 1'b1);
    wait_drained();

    set_grid(32'h12345678, 32'hEDCBA987, 32'h00000001, 32'h00000001, 8, 1, 16);
    tx_idle_pct = 20; rx_stall_pct = 20;
    random_points(180, 1'b0);
    wait_drained();

    // back to the reset geometry, dense rewrites
    set_grid(32'h0, 32'h0, 32'h0, 32'h00010000, 64, 64, 64);
    tx_idle_pct = 0; rx_stall_pct = 0;
    random_points(180, 1'b0);
    wait_drained();

    $display("covered %0d points, %0d results, %0d outside the grid, %0d voxels occupied",
             items_sent, results_seen, outside_seen, occ_tally);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("voxel_occupancy_grid verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("voxel_occupancy_grid verification failed");
    end
    $finish;
  end

endmodule
